/* rtl/fcspq_pkg.sv */
`timescale 1ns / 1ps

package fcspq_pkg;

	localparam int DEFAULT_QUEUE_DEPTH = 16;
	localparam int NUM_CLASSES = 4;

	localparam logic [7:0] CODE_V = 8'd86;
	localparam logic [7:0] CODE_A = 8'd65;
	localparam logic [7:0] CODE_D = 8'd68;
	localparam logic [7:0] CODE_B = 8'd66;

	localparam logic [1:0] CLASS_V = 2'd0;
	localparam logic [1:0] CLASS_A = 2'd1;
	localparam logic [1:0] CLASS_D = 2'd2;
	localparam logic [1:0] CLASS_B = 2'd3;

	localparam logic [10:0] MIN_PER_HOUR = 11'd60;
	localparam logic [4:0] MAX_HOUR = 5'd23;
	localparam logic [5:0] MAX_MINUTE = 6'd59;

	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_SERVE = 1'b1;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_BAD_TIME = 3'd1;
	localparam logic [2:0] ST_BAD_CLASS = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;

	localparam logic [15:0] SAT16 = 16'hFFFF;
	localparam logic [6:0] PEAK_MAX = 7'd127;

	// stored entry: ticket and arrival minutes
	typedef struct packed {
		logic [15:0] ticket;
		logic [10:0] arrival;
	} entry_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic finish;
	} cmd_t;

	// bit 2 flags a known code, bits 1:0 give the class index
	function automatic logic [2:0] class_of(input logic [7:0] code);
		logic [2:0] r;
		case (code)
			CODE_V: r = {1'b1, CLASS_V};
			CODE_A: r = {1'b1, CLASS_A};
			CODE_D: r = {1'b1, CLASS_D};
			CODE_B: r = {1'b1, CLASS_B};
			default: r = 3'b000;
		endcase
		return r;
	endfunction

endpackage

/* rtl/fcspq_ctrl.sv */
`timescale 1ns / 1ps

module fcspq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output fcspq_pkg::cmd_t  cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_EXEC;
			end
			S_EXEC: state_d = S_FIN;
			S_FIN:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign cmd = '{
		load:   start && (state_q == S_IDLE),
		exec:   (state_q == S_EXEC),
		finish: (state_q == S_FIN)
	};

endmodule

/* rtl/fcspq_dp.sv */
`timescale 1ns / 1ps

module fcspq_dp #(
	parameter int QUEUE_DEPTH = fcspq_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fcspq_pkg::cmd_t        cmd,
	input  logic                   operation,
	input  logic [15:0]            ticket,
	input  logic [7:0]             class_code,
	input  logic [4:0]             hour,
	input  logic [5:0]             minute,
	output logic                   done,
	output logic [2:0]             status,
	output logic [15:0]            served_ticket,
	output logic [1:0]             served_class,
	output logic [10:0]            arrival_minutes,
	output logic signed [11:0]     wait_minutes,
	output logic [15:0]            served_total,
	output logic [6:0]             peak_occupancy,
	output logic [10:0]            max_wait,
	output logic [15:0]            served_class_v,
	output logic [15:0]            served_class_a,
	output logic [15:0]            served_class_d,
	output logic [15:0]            served_class_b
);

	localparam int NC = fcspq_pkg::NUM_CLASSES;
	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int TW = CW + 2;
	localparam int AW = IW + 2;
	localparam int MEM_DEPTH = NC << IW;

	// latched item
	logic        op_q;
	logic [15:0] ticket_q;
	logic [7:0]  code_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;

	// queue state
	logic [IW-1:0] head_q [NC];
	logic [CW-1:0] count_q [NC];
	logic [15:0]   cls_cnt_q [NC];
	logic [15:0]   total_q;
	logic [6:0]    peak_q;
	logic [10:0]   longest_q;

	// between execute and finish
	logic [2:0]  st_q;
	logic [1:0]  sel_q;
	logic        served_q;
	logic [10:0] now_q;
	fcspq_pkg::entry_t rd_q;

	fcspq_pkg::entry_t mem [MEM_DEPTH];

	logic          time_bad;
	logic [2:0]    dec;
	logic          any;
	logic [1:0]    pick;
	logic [1:0]    sel;
	logic [2:0]    st_d;
	logic          push;
	logic          pop;
	logic [SW-1:0] pos_sum;
	logic [IW-1:0] pos;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [IW-1:0] head_nx;
	logic [TW-1:0] occ;
	logic [6:0]    occ_sat;
	logic [10:0]   now_d;
	logic signed [11:0] wait_d;

	always_comb begin
		time_bad = (hour_q > fcspq_pkg::MAX_HOUR) || (minute_q > fcspq_pkg::MAX_MINUTE);
		now_d = 11'(hour_q) * fcspq_pkg::MIN_PER_HOUR + 11'(minute_q);
		dec = fcspq_pkg::class_of(code_q);

		// most urgent nonempty queue wins
		any = 1'b0;
		pick = fcspq_pkg::CLASS_V;
		for (int k = NC - 1; k >= 0; k--) begin
			if (count_q[k] != '0) begin
				any = 1'b1;
				pick = 2'(k);
			end
		end

		sel = (op_q == fcspq_pkg::OP_SERVE) ? pick : dec[1:0];
		st_d = fcspq_pkg::ST_OK;
		push = 1'b0;
		pop = 1'b0;
		if (time_bad) begin
			st_d = fcspq_pkg::ST_BAD_TIME;
		end else if (op_q == fcspq_pkg::OP_ARRIVE) begin
			if (!dec[2]) begin
				st_d = fcspq_pkg::ST_BAD_CLASS;
			end else if (count_q[sel] == CW'(QUEUE_DEPTH)) begin
				st_d = fcspq_pkg::ST_FULL;
			end else begin
				push = 1'b1;
			end
		end else begin
			if (!any) begin
				st_d = fcspq_pkg::ST_EMPTY;
			end else begin
				pop = 1'b1;
			end
		end

		pos_sum = SW'(head_q[sel]) + SW'(count_q[sel]);
		pos = (pos_sum >= SW'(QUEUE_DEPTH)) ? IW'(pos_sum - SW'(QUEUE_DEPTH))
			: pos_sum[IW-1:0];
		waddr = {sel, pos};
		raddr = {sel, head_q[sel]};
		head_nx = (head_q[sel] == IW'(QUEUE_DEPTH - 1)) ? '0 : head_q[sel] + 1'b1;

		// total waiting after this arrival
		occ = TW'(count_q[0]) + TW'(count_q[1]) + TW'(count_q[2]) + TW'(count_q[3])
			+ TW'(1);
		occ_sat = (occ > TW'(fcspq_pkg::PEAK_MAX)) ? fcspq_pkg::PEAK_MAX : occ[6:0];

		wait_d = $signed({1'b0, now_q}) - $signed({1'b0, rd_q.arrival});
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			ticket_q <= ticket;
			code_q <= class_code;
			hour_q <= hour;
			minute_q <= minute;
		end
		if (cmd.exec) begin
			st_q <= st_d;
			sel_q <= sel;
			served_q <= pop;
			now_q <= now_d;
			if (push) mem[waddr] <= '{ticket: ticket_q, arrival: now_d};
			if (pop) rd_q <= mem[raddr];
		end
		if (cmd.finish) begin
			status <= st_q;
			if (served_q) begin
				served_ticket <= rd_q.ticket;
				served_class <= sel_q;
				arrival_minutes <= rd_q.arrival;
				wait_minutes <= wait_d;
			end else begin
				served_ticket <= '0;
				served_class <= '0;
				arrival_minutes <= '0;
				wait_minutes <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NC; k++) begin
				head_q[k] <= '0;
				count_q[k] <= '0;
				cls_cnt_q[k] <= '0;
			end
			total_q <= '0;
			peak_q <= '0;
			longest_q <= '0;
			done <= 1'b0;
		end else begin
			done <= cmd.finish;
			if (cmd.exec && push) begin
				count_q[sel] <= count_q[sel] + 1'b1;
				if (occ_sat > peak_q) peak_q <= occ_sat;
			end
			if (cmd.exec && pop) begin
				count_q[sel] <= count_q[sel] - 1'b1;
				head_q[sel] <= head_nx;
			end
			if (cmd.finish && served_q) begin
				if (cls_cnt_q[sel_q] != fcspq_pkg::SAT16)
					cls_cnt_q[sel_q] <= cls_cnt_q[sel_q] + 1'b1;
				if (total_q != fcspq_pkg::SAT16) total_q <= total_q + 1'b1;
				if (!wait_d[11] && (wait_d[10:0] > longest_q)) longest_q <= wait_d[10:0];
			end
		end
	end

	assign served_total = total_q;
	assign peak_occupancy = peak_q;
	assign max_wait = longest_q;
	assign served_class_v = cls_cnt_q[fcspq_pkg::CLASS_V];
	assign served_class_a = cls_cnt_q[fcspq_pkg::CLASS_A];
	assign served_class_d = cls_cnt_q[fcspq_pkg::CLASS_D];
	assign served_class_b = cls_cnt_q[fcspq_pkg::CLASS_B];

endmodule

/* rtl/four_class_strict_priority_queue_top.sv */
`timescale 1ns / 1ps
// four-class strict priority queue
// command channel: an item (operation, ticket, class_code, hour, minute) is
// taken at a clock edge with start high and busy low. operation 0 files an
// arrival in the queue of its class, operation 1 serves the head of the most
// urgent nonempty queue (V, then A, D, B).
// result channel: done is high for one cycle while status and the served
// fields are shown; the statistics ports (served_total, peak_occupancy,
// max_wait, served_class_*) hold their values between items.
// sequence: the item passes the execute state, then the finish state, at
// whose end done rises; the result is taken at the edge after that. busy
// stays high through both states, so a new item is taken only once the last
// is through. the steps are set by the entry memory: execute decides and
// reads or writes it, finish forms the result from the registered read data.
// reset clears all queues and counters at once; memory contents are not
// cleared since only filed entries are ever read. the receiver has no way to
// stall a result: it must take done when it comes.
module four_class_strict_priority_queue_top #(
	parameter int QUEUE_DEPTH = fcspq_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic [15:0]        ticket,
	input  logic [7:0]         class_code,
	input  logic [4:0]         hour,
	input  logic [5:0]         minute,
	output logic               done,
	output logic [2:0]         status,
	output logic [15:0]        served_ticket,
	output logic [1:0]         served_class,
	output logic [10:0]        arrival_minutes,
	output logic signed [11:0] wait_minutes,
	output logic [15:0]        served_total,
	output logic [6:0]         peak_occupancy,
	output logic [10:0]        max_wait,
	output logic [15:0]        served_class_v,
	output logic [15:0]        served_class_a,
	output logic [15:0]        served_class_d,
	output logic [15:0]        served_class_b
);

	fcspq_pkg::cmd_t cmd;

	fcspq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	fcspq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.operation       (operation),
		.ticket          (ticket),
		.class_code      (class_code),
		.hour            (hour),
		.minute          (minute),
		.done            (done),
		.status          (status),
		.served_ticket   (served_ticket),
		.served_class    (served_class),
		.arrival_minutes (arrival_minutes),
		.wait_minutes    (wait_minutes),
		.served_total    (served_total),
		.peak_occupancy  (peak_occupancy),
		.max_wait        (max_wait),
		.served_class_v  (served_class_v),
		.served_class_a  (served_class_a),
		.served_class_d  (served_class_d),
		.served_class_b  (served_class_b)
	);

endmodule
